@@ rtl/core/ucfd_pkg.sv @@
// shared types, constants and tables of the uart command frame decoder
// used by ucfd_front, ucfd_queue, ucfd_back and uart_command_frame_decoder
// depends on nothing
`default_nettype none

package ucfd_pkg;

	// frame length limit and derived widths
	localparam int FRAME_MAX   = 64;
	localparam int CNT_W       = $clog2(FRAME_MAX + 1);
	localparam int STORE_DEPTH = 7;
	localparam int STORE_IDX_W = $clog2(STORE_DEPTH);

	// queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// input kinds
	localparam logic OP_BYTE    = 1'b0;
	localparam logic OP_TIMEOUT = 1'b1;

	// frame framing bytes
	localparam logic [7:0] HDR0_BYTE = 8'h41;
	localparam logic [7:0] HDR1_BYTE = 8'h44;
	localparam logic [7:0] TERM_BYTE = 8'hFE;

	// command bytes
	localparam logic [7:0] CMD_TV  = 8'h54;
	localparam logic [7:0] CMD_PIC = 8'h4E;
	localparam logic [7:0] CMD_SW  = 8'h53;

	// picture register addresses
	localparam logic [7:0] PIC_BRIGHT = 8'h0A;
	localparam logic [7:0] PIC_CONTR  = 8'h08;
	localparam logic [7:0] PIC_SAT    = 8'hE3;

	// switch command arguments
	localparam logic [7:0] ARG_ON         = 8'hFD;
	localparam logic [7:0] ARG_OFF        = 8'h01;
	localparam logic [7:0] ARG_SMOOTH_ON  = 8'h90;
	localparam logic [7:0] ARG_SMOOTH_OFF = 8'h91;
	localparam logic [7:0] ARG_DOUBLE_ON  = 8'h30;
	localparam logic [7:0] ARG_DOUBLE_OFF = 8'h31;
	localparam logic [7:0] ARG_COMPAT_ON  = 8'hA0;
	localparam logic [7:0] ARG_COMPAT_OFF = 8'hA1;
	localparam logic [7:0] ARG_YPBPR      = 8'h70;
	localparam logic [7:0] ARG_ACE_ON     = 8'h80;
	localparam logic [7:0] ARG_ACE_OFF    = 8'h81;

	// switch command argument classes by high nibble
	localparam logic [3:0] NIB_SVIDEO = 4'h1;
	localparam logic [3:0] NIB_CVBS   = 4'h2;
	localparam logic [3:0] NIB_RGBS   = 4'h4;
	localparam logic [3:0] NIB_RGSB   = 4'h5;
	localparam logic [3:0] NIB_VGA    = 4'h6;

	// action codes
	localparam logic [4:0] ACT_REJECT     = 5'd0;
	localparam logic [4:0] ACT_TV         = 5'd1;
	localparam logic [4:0] ACT_PICTURE    = 5'd2;
	localparam logic [4:0] ACT_ON         = 5'd3;
	localparam logic [4:0] ACT_OFF        = 5'd4;
	localparam logic [4:0] ACT_SVIDEO     = 5'd5;
	localparam logic [4:0] ACT_CVBS       = 5'd6;
	localparam logic [4:0] ACT_SMOOTH_ON  = 5'd7;
	localparam logic [4:0] ACT_SMOOTH_OFF = 5'd8;
	localparam logic [4:0] ACT_DOUBLE_ON  = 5'd9;
	localparam logic [4:0] ACT_DOUBLE_OFF = 5'd10;
	localparam logic [4:0] ACT_COMPAT_ON  = 5'd11;
	localparam logic [4:0] ACT_COMPAT_OFF = 5'd12;
	localparam logic [4:0] ACT_RGBS       = 5'd13;
	localparam logic [4:0] ACT_RGSB       = 5'd14;
	localparam logic [4:0] ACT_VGA        = 5'd15;
	localparam logic [4:0] ACT_YPBPR      = 5'd16;
	localparam logic [4:0] ACT_ACE_ON     = 5'd17;
	localparam logic [4:0] ACT_ACE_OFF    = 5'd18;
	localparam logic [4:0] ACT_UNKNOWN    = 5'd19;

	// input source codes
	localparam logic [2:0] SRC_RGBS   = 3'd1;
	localparam logic [2:0] SRC_RGSB   = 3'd2;
	localparam logic [2:0] SRC_VGA    = 3'd3;
	localparam logic [2:0] SRC_YPBPR  = 3'd4;
	localparam logic [2:0] SRC_SVIDEO = 3'd5;
	localparam logic [2:0] SRC_CVBS   = 3'd6;

	// mode flag bit positions
	localparam int FLAG_VIDEO  = 0;
	localparam int FLAG_DOUBLE = 1;
	localparam int FLAG_SMOOTH = 2;
	localparam int FLAG_ACE    = 3;

	// register map
	localparam logic REG_VIDEO_SELECT = 1'b0;
	localparam logic [7:0] VIDEO_SELECT_RESET = 8'd7;

	// tv standard code by low nibble of an s-video or composite argument
	localparam logic [7:0] STD_CODE [16] = '{
		8'h04, 8'h04, 8'h84, 8'h54, 8'h64, 8'h74, 8'h44, 8'h94,
		8'hA4, 8'hB4, 8'hC4, 8'hD4, 8'hE4, 8'h04, 8'h04, 8'h04
	};

	// one ended frame as classified by the front
	typedef struct packed {
		logic       ok;
		logic [7:0] cmd;
		logic [7:0] arg;
		logic [7:0] prm;
	} frame_t;

	// one result item
	typedef struct packed {
		logic       frame_ok;
		logic [4:0] action;
		logic       write_valid;
		logic [7:0] write_reg;
		logic [7:0] write_value;
		logic [7:0] switch_state;
		logic       switch_changed;
		logic [2:0] input_source;
		logic       video_enable;
		logic       double_line;
		logic       smooth;
		logic       ace;
	} result_t;

endpackage

`default_nettype wire

@@ rtl/core/ucfd_front.sv @@
// front of the uart command frame decoder: byte capture, frame end, frame check
// depends on ucfd_pkg
`default_nettype none

module ucfd_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire logic            in_op,
	input  wire logic [7:0]      in_byte,
	output logic                 push,
	output ucfd_pkg::frame_t     push_frame,
	input  wire logic            queue_full
);

	logic [7:0]                 store_q [ucfd_pkg::STORE_DEPTH];
	logic [7:0]                 store_n [ucfd_pkg::STORE_DEPTH];
	logic [ucfd_pkg::CNT_W-1:0] cnt_q;
	logic [ucfd_pkg::CNT_W-1:0] cnt_inc;
	logic                       is_byte;
	logic                       accept;
	logic                       frame_end;
	logic [7:0]                 sum;
	logic                       ok;

	assign in_ready = ~queue_full;
	assign accept   = in_valid & in_ready;
	assign is_byte  = (in_op == ucfd_pkg::OP_BYTE);
	assign cnt_inc  = cnt_q + ucfd_pkg::CNT_W'(1);

	// store contents with this byte placed
	always_comb begin
		for (int i = 0; i < ucfd_pkg::STORE_DEPTH; i++) begin
			store_n[i] = store_q[i];
		end
		if (is_byte && (cnt_q < ucfd_pkg::CNT_W'(ucfd_pkg::STORE_DEPTH))) begin
			store_n[cnt_q[ucfd_pkg::STORE_IDX_W-1:0]] = in_byte;
		end
	end

	// frame end: length limit reached or timeout after at least one byte
	assign frame_end = is_byte ? (cnt_inc == ucfd_pkg::CNT_W'(ucfd_pkg::FRAME_MAX))
	                           : (cnt_q != '0);

	// header, terminator and checksum
	assign sum = store_n[0] + store_n[1] + store_n[2] + store_n[3] + store_n[4] + store_n[5];
	assign ok  = (store_n[0] == ucfd_pkg::HDR0_BYTE) && (store_n[1] == ucfd_pkg::HDR1_BYTE) &&
	             (store_n[5] == ucfd_pkg::TERM_BYTE) && (store_n[6] == sum);

	assign push           = accept & frame_end;
	assign push_frame.ok  = ok;
	assign push_frame.cmd = store_n[2];
	assign push_frame.arg = store_n[3];
	assign push_frame.prm = store_n[4];

	// capture store and byte counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			for (int i = 0; i < ucfd_pkg::STORE_DEPTH; i++) begin
				store_q[i] <= '0;
			end
		end else if (accept) begin
			if (frame_end) begin
				cnt_q <= '0;
				for (int i = 0; i < ucfd_pkg::STORE_DEPTH; i++) begin
					store_q[i] <= ok ? store_n[i] : 8'd0;
				end
			end else if (is_byte) begin
				cnt_q <= cnt_inc;
				for (int i = 0; i < ucfd_pkg::STORE_DEPTH; i++) begin
					store_q[i] <= store_n[i];
				end
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/ucfd_queue.sv @@
// short frame queue between front and back of the uart command frame decoder
// depends on ucfd_pkg
`default_nettype none

module ucfd_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire ucfd_pkg::frame_t push_frame,
	output logic                  full,
	output logic                  head_valid,
	output ucfd_pkg::frame_t      head_frame,
	input  wire logic             pop
);

	ucfd_pkg::frame_t            entry_q [ucfd_pkg::QUEUE_DEPTH];
	logic [ucfd_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [ucfd_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [ucfd_pkg::QCNT_W-1:0] count_q;
	logic                        do_push;
	logic                        do_pop;

	assign full       = (count_q == ucfd_pkg::QCNT_W'(ucfd_pkg::QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_frame = entry_q[rd_ptr_q];
	assign do_push    = push & ~full;
	assign do_pop     = pop & head_valid;

	// entries
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_frame;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == ucfd_pkg::QPTR_W'(ucfd_pkg::QUEUE_DEPTH - 1)) ? '0
				            : wr_ptr_q + ucfd_pkg::QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == ucfd_pkg::QPTR_W'(ucfd_pkg::QUEUE_DEPTH - 1)) ? '0
				            : rd_ptr_q + ucfd_pkg::QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + ucfd_pkg::QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - ucfd_pkg::QCNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/ucfd_back.sv @@
// back of the uart command frame decoder: command execution, kept settings,
// result register; depends on ucfd_pkg
`default_nettype none

module ucfd_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             head_valid,
	input  wire ucfd_pkg::frame_t head_frame,
	output logic                  pop,
	input  wire logic [7:0]       video_select,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output ucfd_pkg::result_t     out_result
);

	logic [7:0]        sw_q;
	logic [2:0]        src_q;
	logic [3:0]        flags_q;
	logic              out_valid_q;
	ucfd_pkg::result_t out_result_q;

	logic [7:0]        sw_n;
	logic [2:0]        src_n;
	logic [3:0]        flags_n;
	ucfd_pkg::result_t res;
	logic [7:0]        a;
	logic [3:0]        hi;

	// switch word with bit 7 (av connect) kept
	function automatic logic [7:0] set_sw(input logic [7:0] cur, input logic s1,
	                                      input logic [3:0] s2, input logic s3,
	                                      input logic s4);
		set_sw = {cur[7], s4, s3, s2, s1};
	endfunction

	assign a  = head_frame.arg;
	assign hi = a[7:4];

	// command decode against the kept settings
	always_comb begin
		sw_n    = sw_q;
		src_n   = src_q;
		flags_n = flags_q;
		res     = '0;
		res.frame_ok = head_frame.ok;
		res.action   = head_frame.ok ? ucfd_pkg::ACT_UNKNOWN : ucfd_pkg::ACT_REJECT;
		if (head_frame.ok) begin
			priority if (head_frame.cmd == ucfd_pkg::CMD_TV) begin
				res.action      = ucfd_pkg::ACT_TV;
				res.write_valid = 1'b1;
				res.write_reg   = video_select;
				res.write_value = a;
			end else if (head_frame.cmd == ucfd_pkg::CMD_PIC) begin
				if (a == ucfd_pkg::PIC_BRIGHT || a == ucfd_pkg::PIC_CONTR ||
				    a == ucfd_pkg::PIC_SAT) begin
					res.action      = ucfd_pkg::ACT_PICTURE;
					res.write_valid = 1'b1;
					res.write_reg   = a;
					res.write_value = head_frame.prm;
				end
			end else if (head_frame.cmd == ucfd_pkg::CMD_SW) begin
				priority if (a == ucfd_pkg::ARG_ON) begin
					res.action = ucfd_pkg::ACT_ON;
					flags_n[ucfd_pkg::FLAG_VIDEO] = 1'b1;
				end else if (a == ucfd_pkg::ARG_OFF) begin
					res.action = ucfd_pkg::ACT_OFF;
					flags_n[ucfd_pkg::FLAG_VIDEO] = 1'b0;
				end else if (hi == ucfd_pkg::NIB_SVIDEO || hi == ucfd_pkg::NIB_CVBS) begin
					res.action = (hi == ucfd_pkg::NIB_SVIDEO) ? ucfd_pkg::ACT_SVIDEO
					                                          : ucfd_pkg::ACT_CVBS;
					sw_n = set_sw({1'b1, sw_q[6:0]}, 1'b0, 4'd0, 1'b1, 1'b0);
					res.switch_changed = 1'b1;
					flags_n[ucfd_pkg::FLAG_VIDEO] = 1'b1;
					src_n = (hi == ucfd_pkg::NIB_SVIDEO) ? ucfd_pkg::SRC_SVIDEO
					                                     : ucfd_pkg::SRC_CVBS;
					// nonzero low nibble selects a tv standard
					if (a[3:0] != 4'd0) begin
						res.write_valid = 1'b1;
						res.write_reg   = video_select;
						res.write_value = ucfd_pkg::STD_CODE[a[3:0]];
					end
				end else if (a == ucfd_pkg::ARG_SMOOTH_ON || a == ucfd_pkg::ARG_SMOOTH_OFF) begin
					res.action = (a == ucfd_pkg::ARG_SMOOTH_ON) ? ucfd_pkg::ACT_SMOOTH_ON
					                                            : ucfd_pkg::ACT_SMOOTH_OFF;
					// smoothing only follows while line doubling is on
					if (flags_q[ucfd_pkg::FLAG_DOUBLE]) begin
						flags_n[ucfd_pkg::FLAG_SMOOTH] = (a == ucfd_pkg::ARG_SMOOTH_ON);
					end
				end else if (a == ucfd_pkg::ARG_DOUBLE_ON) begin
					res.action = ucfd_pkg::ACT_DOUBLE_ON;
					flags_n[ucfd_pkg::FLAG_DOUBLE] = 1'b1;
				end else if (a == ucfd_pkg::ARG_DOUBLE_OFF) begin
					res.action = ucfd_pkg::ACT_DOUBLE_OFF;
					flags_n[ucfd_pkg::FLAG_DOUBLE] = 1'b0;
					flags_n[ucfd_pkg::FLAG_SMOOTH] = 1'b0;
				end else if (a == ucfd_pkg::ARG_COMPAT_ON || a == ucfd_pkg::ARG_COMPAT_OFF) begin
					res.action = (a == ucfd_pkg::ARG_COMPAT_ON) ? ucfd_pkg::ACT_COMPAT_ON
					                                            : ucfd_pkg::ACT_COMPAT_OFF;
					sw_n = set_sw(sw_q, sw_q[0], {3'd0, (a == ucfd_pkg::ARG_COMPAT_ON)},
					              sw_q[5], sw_q[6]);
					res.switch_changed = 1'b1;
				end else if (hi == ucfd_pkg::NIB_RGBS || hi == ucfd_pkg::NIB_RGSB) begin
					res.action = (hi == ucfd_pkg::NIB_RGBS) ? ucfd_pkg::ACT_RGBS
					                                        : ucfd_pkg::ACT_RGSB;
					sw_n = set_sw({1'b0, sw_q[6:0]}, 1'b0, {3'd0, a[0]},
					              (hi == ucfd_pkg::NIB_RGSB), (hi == ucfd_pkg::NIB_RGBS));
					res.switch_changed = 1'b1;
					flags_n[ucfd_pkg::FLAG_VIDEO] = 1'b0;
					src_n = (hi == ucfd_pkg::NIB_RGBS) ? ucfd_pkg::SRC_RGBS
					                                   : ucfd_pkg::SRC_RGSB;
				end else if (hi == ucfd_pkg::NIB_VGA) begin
					res.action = ucfd_pkg::ACT_VGA;
					sw_n = set_sw(sw_q, 1'b1, a[3:0], 1'b1, 1'b1);
					res.switch_changed = 1'b1;
					flags_n[ucfd_pkg::FLAG_VIDEO] = 1'b0;
					src_n = ucfd_pkg::SRC_VGA;
				end else if (a == ucfd_pkg::ARG_YPBPR) begin
					res.action = ucfd_pkg::ACT_YPBPR;
					sw_n = set_sw(sw_q, 1'b0, 4'd0, 1'b1, 1'b0);
					res.switch_changed = 1'b1;
					flags_n[ucfd_pkg::FLAG_VIDEO] = 1'b0;
					src_n = ucfd_pkg::SRC_YPBPR;
				end else if (a == ucfd_pkg::ARG_ACE_ON || a == ucfd_pkg::ARG_ACE_OFF) begin
					res.action = (a == ucfd_pkg::ARG_ACE_ON) ? ucfd_pkg::ACT_ACE_ON
					                                         : ucfd_pkg::ACT_ACE_OFF;
					flags_n[ucfd_pkg::FLAG_ACE] = (a == ucfd_pkg::ARG_ACE_ON);
				end else begin
					res.action = ucfd_pkg::ACT_UNKNOWN;
				end
			end else begin
				res.action = ucfd_pkg::ACT_UNKNOWN;
			end
		end
		res.switch_state = sw_n;
		res.input_source = src_n;
		res.video_enable = flags_n[ucfd_pkg::FLAG_VIDEO];
		res.double_line  = flags_n[ucfd_pkg::FLAG_DOUBLE];
		res.smooth       = flags_n[ucfd_pkg::FLAG_SMOOTH];
		res.ace          = flags_n[ucfd_pkg::FLAG_ACE];
	end

	// take the next frame whenever the result register is free or drains
	assign pop        = head_valid & (~out_valid_q | out_ready);
	assign out_valid  = out_valid_q;
	assign out_result = out_result_q;

	// kept settings and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_q        <= '0;
			src_q       <= '0;
			flags_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				sw_q    <= sw_n;
				src_q   <= src_n;
				flags_q <= flags_n;
			end
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (pop) begin
			out_result_q <= res;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/uart_command_frame_decoder.sv @@
// top level of the uart command frame decoder: stream ports, register port,
// front, frame queue and back; depends on ucfd_pkg, ucfd_front, ucfd_queue, ucfd_back
`default_nettype none

// Takes one request per clock: a received UART byte (s_tuser = 0) or an idle
// timeout (s_tuser = 1). Bytes are captured into a seven-byte frame store while
// a counter runs; a frame ends on a timeout after at least one byte or on the
// 64th byte. Each ended frame yields exactly one result on the m side. The
// front checks header, terminator and checksum in the same cycle that it
// accepts the ending request and writes the frame into the queue at that edge.
// The back takes the frame from the queue head and decodes the command into
// the result register whenever that register is free or drains, and m_tvalid
// stays high until the result is taken. A two-entry frame queue parts
// the two halves, so the input keeps taking one request per cycle while a
// result waits; s_tready only drops when that queue is full. Register
// video_select (byte address 0) gives the decoder register address used for
// TV standard writes and resets to 7; write it only while no frame is in flight.
module uart_command_frame_decoder (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  wire logic [0:0]  s_tuser,   // [0] op
	// result stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata,   // [0] frame_ok, [5:1] action, [6] write_valid,
	                                    // [14:7] write_reg, [22:15] write_value,
	                                    // [30:23] switch_state, [31] switch_changed,
	                                    // [34:32] input_source, [35] video_enable,
	                                    // [36] double_line, [37] smooth, [38] ace,
	                                    // [39] zero
	// register port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	logic              push;
	ucfd_pkg::frame_t  push_frame;
	logic              queue_full;
	logic              head_valid;
	ucfd_pkg::frame_t  head_frame;
	logic              pop;
	logic [7:0]        video_select_q;
	ucfd_pkg::result_t result;

	// register port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == ucfd_pkg::REG_VIDEO_SELECT) ? {24'd0, video_select_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			video_select_q <= ucfd_pkg::VIDEO_SELECT_RESET;
		end else if (psel && penable && pwrite && pready &&
		             (paddr[2] == ucfd_pkg::REG_VIDEO_SELECT)) begin
			video_select_q <= pwdata[7:0];
		end
	end

	ucfd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_op      (s_tuser[0]),
		.in_byte    (s_tdata),
		.push       (push),
		.push_frame (push_frame),
		.queue_full (queue_full)
	);

	ucfd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_frame (push_frame),
		.full       (queue_full),
		.head_valid (head_valid),
		.head_frame (head_frame),
		.pop        (pop)
	);

	ucfd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head_frame   (head_frame),
		.pop          (pop),
		.video_select (video_select_q),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_result   (result)
	);

	// result packing, first field lowest
	assign m_tdata = {1'b0, result.ace, result.smooth, result.double_line,
	                  result.video_enable, result.input_source, result.switch_changed,
	                  result.switch_state, result.write_value, result.write_reg,
	                  result.write_valid, result.action, result.frame_ok};

endmodule

`default_nettype wire

@@ test/uart_command_frame_decoder_test.sv @@
// testbench of the uart command frame decoder: random and directed byte/timeout
// streams, a scoreboard class that predicts each frame result, apb register writes
// depends on ucfd_pkg and uart_command_frame_decoder
`timescale 1ns / 100ps

module uart_command_frame_decoder_test;

	import ucfd_pkg::*;

	localparam int STALL_LIMIT = 5000;
	localparam int PHASE_ITEMS = 165;

	// result prediction and checking
	class decoder_scoreboard;
		logic [7:0] select_reg = VIDEO_SELECT_RESET;
		logic [7:0] frame_store [STORE_DEPTH] = '{default: 8'd0};
		logic [7:0] tv_standard = 8'd0;
		logic [7:0] picture_levels [3] = '{default: 8'd0};
		logic [7:0] switch_bits = 8'd0;
		logic [2:0] source_select = 3'd0;
		logic [3:0] mode_flags = 4'd0;
		int byte_count = 0;
		int counted_items = 0;
		int errors = 0;
		result_t pending_results [$];

		function void set_switches(logic s1, logic [3:0] s2, logic s3, logic s4);
			switch_bits = {switch_bits[7], s4, s3, s2, s1};
		endfunction

		function void compare_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				errors++;
				if (errors <= 10)
					$display("mismatch in %s: expected %0d, got %0d", name, want, got);
			end
		endfunction

		// one accepted request, queues the result of a frame that it ends
		function void note_request(logic op, logic [7:0] rx);
			logic [7:0] sum;
			logic [7:0] cmd;
			logic [7:0] arg;
			logic [3:0] hi;
			result_t r;
			if (op == OP_BYTE) begin
				if (byte_count < STORE_DEPTH)
					frame_store[byte_count] = rx;
				byte_count++;
				counted_items++;
				if (byte_count < FRAME_MAX)
					return;
			end else begin
				// timeout on an empty frame is dropped
				if (byte_count == 0)
					return;
				counted_items++;
			end
			byte_count = 0;
			r = '0;
			sum = 8'd0;
			for (int i = 0; i < 6; i++)
				sum += frame_store[i];

			if (frame_store[0] != HDR0_BYTE || frame_store[1] != HDR1_BYTE ||
			    frame_store[5] != TERM_BYTE || frame_store[6] != sum) begin
				foreach (frame_store[i])
					frame_store[i] = 8'd0;
				r.action = ACT_REJECT;
			end else begin
				r.frame_ok = 1'b1;
				cmd = frame_store[2];
				arg = frame_store[3];
				hi = arg[7:4];
				r.action = ACT_UNKNOWN;
				if (cmd == CMD_TV) begin
					r.action = ACT_TV;
					tv_standard = arg;
					r.write_valid = 1'b1;
					r.write_reg = select_reg;
					r.write_value = arg;
				end else if (cmd == CMD_PIC) begin
					if (arg == PIC_BRIGHT || arg == PIC_CONTR || arg == PIC_SAT) begin
						r.action = ACT_PICTURE;
						r.write_valid = 1'b1;
						r.write_reg = arg;
						r.write_value = frame_store[4];
						if (arg == PIC_BRIGHT)
							picture_levels[0] = frame_store[4];
						else if (arg == PIC_CONTR)
							picture_levels[1] = frame_store[4];
						else
							picture_levels[2] = frame_store[4];
					end
				end else if (cmd == CMD_SW) begin
					if (arg == ARG_ON) begin
						r.action = ACT_ON;
						mode_flags[FLAG_VIDEO] = 1'b1;
					end else if (arg == ARG_OFF) begin
						r.action = ACT_OFF;
						mode_flags[FLAG_VIDEO] = 1'b0;
					end else if (hi == NIB_SVIDEO || hi == NIB_CVBS) begin
						// analog video inputs, optional standard write from low nibble
						r.action = (hi == NIB_SVIDEO) ? ACT_SVIDEO : ACT_CVBS;
						switch_bits[7] = 1'b1;
						set_switches(1'b0, 4'd0, 1'b1, 1'b0);
						r.switch_changed = 1'b1;
						mode_flags[FLAG_VIDEO] = 1'b1;
						source_select = (hi == NIB_SVIDEO) ? SRC_SVIDEO : SRC_CVBS;
						if (arg[3:0] != 4'd0) begin
							tv_standard = STD_CODE[arg[3:0]];
							r.write_valid = 1'b1;
							r.write_reg = select_reg;
							r.write_value = tv_standard;
						end
					end else if (arg == ARG_SMOOTH_ON || arg == ARG_SMOOTH_OFF) begin
						// smoothing only follows while line doubling is on
						r.action = (arg == ARG_SMOOTH_ON) ? ACT_SMOOTH_ON : ACT_SMOOTH_OFF;
						if (mode_flags[FLAG_DOUBLE])
							mode_flags[FLAG_SMOOTH] = (arg == ARG_SMOOTH_ON);
					end else if (arg == ARG_DOUBLE_ON) begin
						r.action = ACT_DOUBLE_ON;
						mode_flags[FLAG_DOUBLE] = 1'b1;
					end else if (arg == ARG_DOUBLE_OFF) begin
						r.action = ACT_DOUBLE_OFF;
						mode_flags[FLAG_DOUBLE] = 1'b0;
						mode_flags[FLAG_SMOOTH] = 1'b0;
					end else if (arg == ARG_COMPAT_ON || arg == ARG_COMPAT_OFF) begin
						r.action = (arg == ARG_COMPAT_ON) ? ACT_COMPAT_ON : ACT_COMPAT_OFF;
						set_switches(switch_bits[0], {3'd0, arg == ARG_COMPAT_ON},
							switch_bits[5], switch_bits[6]);
						r.switch_changed = 1'b1;
					end else if (hi == NIB_RGBS || hi == NIB_RGSB) begin
						r.action = (hi == NIB_RGBS) ? ACT_RGBS : ACT_RGSB;
						switch_bits[7] = 1'b0;
						set_switches(1'b0, {3'd0, arg[0]}, hi == NIB_RGSB, hi == NIB_RGBS);
						r.switch_changed = 1'b1;
						mode_flags[FLAG_VIDEO] = 1'b0;
						source_select = (hi == NIB_RGBS) ? SRC_RGBS : SRC_RGSB;
					end else if (hi == NIB_VGA) begin
						r.action = ACT_VGA;
						set_switches(1'b1, arg[3:0], 1'b1, 1'b1);
						r.switch_changed = 1'b1;
						mode_flags[FLAG_VIDEO] = 1'b0;
						source_select = SRC_VGA;
					end else if (arg == ARG_YPBPR) begin
						r.action = ACT_YPBPR;
						set_switches(1'b0, 4'd0, 1'b1, 1'b0);
						r.switch_changed = 1'b1;
						mode_flags[FLAG_VIDEO] = 1'b0;
						source_select = SRC_YPBPR;
					end else if (arg == ARG_ACE_ON || arg == ARG_ACE_OFF) begin
						r.action = (arg == ARG_ACE_ON) ? ACT_ACE_ON : ACT_ACE_OFF;
						mode_flags[FLAG_ACE] = (arg == ARG_ACE_ON);
					end
				end
			end
			r.switch_state = switch_bits;
			r.input_source = source_select;
			r.video_enable = mode_flags[FLAG_VIDEO];
			r.double_line = mode_flags[FLAG_DOUBLE];
			r.smooth = mode_flags[FLAG_SMOOTH];
			r.ace = mode_flags[FLAG_ACE];
			pending_results.push_back(r);
		endfunction

		// one accepted result against the oldest prediction
		function void check_result(logic [39:0] d);
			result_t want;
			if (pending_results.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("result with none expected: %h", d);
				return;
			end
			want = pending_results.pop_front();
			compare_field("frame_ok", 32'(want.frame_ok), 32'(d[0]));
			compare_field("action", 32'(want.action), 32'(d[5:1]));
			compare_field("write_valid", 32'(want.write_valid), 32'(d[6]));
			compare_field("write_reg", 32'(want.write_reg), 32'(d[14:7]));
			compare_field("write_value", 32'(want.write_value), 32'(d[22:15]));
			compare_field("switch_state", 32'(want.switch_state), 32'(d[30:23]));
			compare_field("switch_changed", 32'(want.switch_changed), 32'(d[31]));
			compare_field("input_source", 32'(want.input_source), 32'(d[34:32]));
			compare_field("video_enable", 32'(want.video_enable), 32'(d[35]));
			compare_field("double_line", 32'(want.double_line), 32'(d[36]));
			compare_field("smooth", 32'(want.smooth), 32'(d[37]));
			compare_field("ace", 32'(want.ace), 32'(d[38]));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [7:0] s_tdata = 8'd0;
	logic [0:0] s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = 3'd0;
	logic [31:0] pwdata = 32'd0;
	logic [31:0] prdata;
	logic pready;

	int snd_idle = 34;
	int rcv_idle = 68;
	int stall_cycles = 0;
	logic [7:0] frame_bytes [STORE_DEPTH];
	decoder_scoreboard sb;

	uart_command_frame_decoder i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// result side stalls
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= rcv_idle);
	end

	// result checking and stall watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				sb.check_result(m_tdata);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("uart_command_frame_decoder_test NOT OK");
				$finish;
			end
		end
	end

	// one request, with random gaps before it
	task automatic send_item(logic op, logic [7:0] rx);
		while ($urandom_range(99) < snd_idle) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= rx;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_request(op, rx);
		@(negedge clk);
	endtask

	// hold off the sender until all results are in and the block is quiet
	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending_results.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic apb_write(logic [7:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {REG_VIDEO_SELECT, 2'b00};
		pwdata <= {24'd0, value};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		sb.select_reg = value;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic apb_read_check();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {REG_VIDEO_SELECT, 2'b00};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		sb.compare_field("video_select", 32'(sb.select_reg), 32'(prdata[7:0]));
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// well-formed frame with matching checksum
	task automatic build_frame(logic [7:0] cmd, logic [7:0] arg, logic [7:0] prm);
		frame_bytes[0] = HDR0_BYTE;
		frame_bytes[1] = HDR1_BYTE;
		frame_bytes[2] = cmd;
		frame_bytes[3] = arg;
		frame_bytes[4] = prm;
		frame_bytes[5] = TERM_BYTE;
		frame_bytes[6] = HDR0_BYTE + HDR1_BYTE + cmd + arg + prm + TERM_BYTE;
	endtask

	task automatic send_prefix(int n);
		for (int i = 0; i < n; i++)
			send_item(OP_BYTE, frame_bytes[i]);
	endtask

	task automatic build_random_frame();
		logic [7:0] cmd;
		logic [7:0] arg;
		int pick;
		pick = $urandom_range(99);
		arg = 8'($urandom_range(255));
		if (pick < 45) begin
			cmd = CMD_SW;
			case ($urandom_range(16))
				0: arg = ARG_ON;
				1: arg = ARG_OFF;
				2: arg = {NIB_SVIDEO, arg[3:0]};
				3: arg = {NIB_CVBS, arg[3:0]};
				4: arg = ARG_SMOOTH_ON;
				5: arg = ARG_SMOOTH_OFF;
				6: arg = ARG_DOUBLE_ON;
				7: arg = ARG_DOUBLE_OFF;
				8: arg = ARG_COMPAT_ON;
				9: arg = ARG_COMPAT_OFF;
				10: arg = {NIB_RGBS, arg[3:0]};
				11: arg = {NIB_RGSB, arg[3:0]};
				12: arg = {NIB_VGA, arg[3:0]};
				13: arg = ARG_YPBPR;
				14: arg = ARG_ACE_ON;
				15: arg = ARG_ACE_OFF;
				default: ;
			endcase
		end else if (pick < 65) begin
			cmd = CMD_TV;
		end else if (pick < 85) begin
			cmd = CMD_PIC;
			case ($urandom_range(3))
				0: arg = PIC_BRIGHT;
				1: arg = PIC_CONTR;
				2: arg = PIC_SAT;
				default: ;
			endcase
		end else begin
			cmd = 8'($urandom_range(255));
		end
		build_frame(cmd, arg, 8'($urandom_range(255)));
	endtask

	// mostly good frames, some corrupted, truncated, overlong or plain noise
	task automatic send_random_frame();
		int kind;
		int pos;
		build_random_frame();
		kind = $urandom_range(99);
		if (kind < 62) begin
			send_prefix(7);
			if ($urandom_range(4) == 0)
				repeat ($urandom_range(1, 5)) send_item(OP_BYTE, 8'($urandom_range(255)));
			send_item(OP_TIMEOUT, 8'($urandom_range(255)));
		end else if (kind < 74) begin
			pos = $urandom_range(6);
			frame_bytes[pos] = frame_bytes[pos] ^ 8'($urandom_range(1, 255));
			send_prefix(7);
			send_item(OP_TIMEOUT, 8'($urandom_range(255)));
		end else if (kind < 84) begin
			send_prefix($urandom_range(1, 6));
			send_item(OP_TIMEOUT, 8'($urandom_range(255)));
		end else if (kind < 89) begin
			// frame ended by length
			send_prefix(7);
			repeat (FRAME_MAX - 7) send_item(OP_BYTE, 8'($urandom_range(255)));
			if ($urandom_range(1) == 0)
				send_item(OP_TIMEOUT, 8'($urandom_range(255)));
		end else begin
			repeat ($urandom_range(1, 8))
				send_item(1'($urandom_range(1)), 8'($urandom_range(255)));
			send_item(OP_TIMEOUT, 8'($urandom_range(255)));
		end
	endtask

	// stimulus sequence
	initial begin
		logic [7:0] select_value;
		int target;
		sb = new;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		apb_read_check();

		// lone timeout is dropped
		send_item(OP_TIMEOUT, 8'hFF);
		// tv mode at the top of the byte range
		build_frame(CMD_TV, 8'hFF, 8'h00);
		send_prefix(7);
		send_item(OP_TIMEOUT, 8'h00);
		// composite without standard write, one byte past the store
		build_frame(CMD_SW, {NIB_CVBS, 4'h0}, 8'hFF);
		send_prefix(7);
		send_item(OP_BYTE, 8'hFF);
		send_item(OP_TIMEOUT, 8'hA5);
		// one-byte frame reuses the rest of the store and passes again
		send_item(OP_BYTE, HDR0_BYTE);
		send_item(OP_TIMEOUT, 8'h5A);
		// bad header rejects and clears the store
		send_item(OP_BYTE, 8'h00);
		send_item(OP_TIMEOUT, 8'hFF);
		send_item(OP_TIMEOUT, 8'h00);

		for (int phase = 0; phase < 3; phase++) begin
			drain();
			case (phase)
				0: begin
					snd_idle = 34;
					rcv_idle = 68;
					select_value = 8'h00;
				end
				1: begin
					snd_idle = 68;
					rcv_idle = 34;
					select_value = 8'hFF;
				end
				default: begin
					snd_idle = 0;
					rcv_idle = 0;
					select_value = 8'($urandom_range(255));
				end
			endcase
			apb_write(select_value);
			apb_read_check();
			target = sb.counted_items + PHASE_ITEMS;
			while (sb.counted_items < target)
				send_random_frame();
		end

		drain();
		repeat (8) @(negedge clk);
		if (sb.errors == 0 && sb.pending_results.size() == 0)
			$display("uart_command_frame_decoder_test OK");
		else
			$display("uart_command_frame_decoder_test NOT OK");
		$finish;
	end

endmodule

@@ uart_command_frame_decoder.f @@
rtl/core/ucfd_pkg.sv
rtl/core/ucfd_front.sv
rtl/core/ucfd_queue.sv
rtl/core/ucfd_back.sv
rtl/core/uart_command_frame_decoder.sv
test/uart_command_frame_decoder_test.sv
